// ===== hdl/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, constants and helpers of the byte-level I2C master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	// Width of the phase tick counter.
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Depth of the command queue between front and engine.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PHASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_STOP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

	localparam logic [7:0] BIT_PHASE_RST   = 8'd2;
	localparam logic [7:0] START_STOP_RST  = 8'd4;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ST_A   = 4'd1,
		PH_ST_B   = 4'd2,
		PH_SP_A   = 4'd3,
		PH_SP_B   = 4'd4,
		PH_W_SET  = 4'd5,
		PH_W_HI   = 4'd6,
		PH_W_LO   = 4'd7,
		PH_A_REL  = 4'd8,
		PH_A_HI   = 4'd9,
		PH_A_POLL = 4'd10,
		PH_R_LO   = 4'd11,
		PH_R_HI   = 4'd12,
		PH_K_SET  = 4'd13,
		PH_K_HI   = 4'd14
	} phase_t;

	// One classified tick as it travels through the queue.
	typedef struct packed {
		logic       launch;
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [7:0] bit_phase_ticks;
		logic [7:0] start_stop_ticks;
		logic [7:0] ack_timeout_polls;
	} cfg_t;

	// A zero length counts as one tick; lengths past the counter saturate.
	function automatic logic [CNT_W-1:0] clamp_len(input logic [7:0] v);
		logic [CNT_W+7:0] wide;
		logic [CNT_W+7:0] lim;
		wide = {{CNT_W{1'b0}}, v};
		lim  = {8'd0, CNT_MAX};
		if (v == 8'd0) begin
			wide = {{(CNT_W+7){1'b0}}, 1'b1};
		end else if (wide > lim) begin
			wide = lim;
		end
		return wide[CNT_W-1:0];
	endfunction

endpackage

// ===== hdl/i2cbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_front
// Accepts ticks, classifies the offered command and queues them for the
// bus engine.
// ----------------------------------------------------------------------------
module i2cbm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd_valid,
	input  logic [1:0]          func,
	input  logic [7:0]          tx_byte,
	input  logic                send_ack,
	input  logic                sda_in,
	output logic                q_valid,
	output i2cbm_pkg::item_t    q_item,
	input  logic                q_pop
);

	i2cbm_pkg::item_t                slot_q [i2cbm_pkg::QDEPTH];
	logic [i2cbm_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [i2cbm_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [i2cbm_pkg::QPTR_W:0]      count_q;
	i2cbm_pkg::item_t                item_in;
	logic                            push;

	localparam logic [i2cbm_pkg::QPTR_W:0] FULL_CNT = (i2cbm_pkg::QPTR_W+1)'(i2cbm_pkg::QDEPTH);
	localparam logic [i2cbm_pkg::QPTR_W-1:0] LAST_PTR =
		i2cbm_pkg::QPTR_W'(i2cbm_pkg::QDEPTH - 1);

	always_comb begin
		item_in.launch   = cmd_valid;
		item_in.cmd      = i2cbm_pkg::cmd_t'(func);
		item_in.tx_byte  = tx_byte;
		item_in.send_ack = send_ack;
		item_in.sda_in   = sda_in;
	end

	assign in_ready = (count_q != FULL_CNT);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone transfer");

endmodule

// ===== hdl/i2cbm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bus engine: advances the I2C phase machine by one tick per queued item
// and holds the line levels and status as the result register.
// ----------------------------------------------------------------------------
module i2cbm_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cbm_pkg::cfg_t     cfg,
	input  logic                q_valid,
	input  i2cbm_pkg::item_t    q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                scl_level,
	output logic                sda_level,
	output logic                sda_drive,
	output logic                busy_res,
	output logic                cmd_done,
	output logic [7:0]          rx_byte,
	output logic                ack_missing
);

	localparam int CW = i2cbm_pkg::CNT_W;

	i2cbm_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0]     tick_q, tick_d, tick_inc, len, ss_len, bp_len;
	logic [3:0]        bit_q, bit_d, bit_inc;
	logic [7:0]        shift_q, shift_d, shift_w, shift_r;
	logic [7:0]        poll_q, poll_d;
	logic [8:0]        poll_n;
	logic [7:0]        rx_q, rx_d;
	logic              scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic              ack_flag_q, ack_flag_d, choice_q, choice_d;
	logic              done_q, done_d;
	logic              out_valid_q;
	logic              step, tick_end, poll_to, bit_last, go;
	i2cbm_pkg::item_t  it;

	assign it    = q_item;
	assign step  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = step;

	assign ss_len   = i2cbm_pkg::clamp_len(cfg.start_stop_ticks);
	assign bp_len   = i2cbm_pkg::clamp_len(cfg.bit_phase_ticks);
	assign len      = (phase_q == i2cbm_pkg::PH_ST_A || phase_q == i2cbm_pkg::PH_ST_B ||
			phase_q == i2cbm_pkg::PH_SP_A || phase_q == i2cbm_pkg::PH_SP_B) ? ss_len : bp_len;
	assign tick_inc = tick_q + CW'(1);
	assign tick_end = (tick_inc >= len);
	assign poll_n   = {1'b0, poll_q} + 9'd1;
	assign poll_to  = (poll_n > {1'b0, cfg.ack_timeout_polls});
	assign bit_inc  = bit_q + 4'd1;
	assign bit_last = (bit_inc >= i2cbm_pkg::BYTE_BITS);
	assign shift_w  = {shift_q[6:0], 1'b0};
	assign shift_r  = {shift_q[6:0], it.sda_in};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			i2cbm_pkg::PH_IDLE: begin
				if (it.launch) begin
					unique case (it.cmd)
						i2cbm_pkg::CMD_START: phase_d = i2cbm_pkg::PH_ST_A;
						i2cbm_pkg::CMD_STOP:  phase_d = i2cbm_pkg::PH_SP_A;
						i2cbm_pkg::CMD_WRITE: phase_d = i2cbm_pkg::PH_W_SET;
						i2cbm_pkg::CMD_READ:  phase_d = i2cbm_pkg::PH_R_LO;
					endcase
				end
			end
			i2cbm_pkg::PH_A_POLL: begin
				if (!it.sda_in) begin
					phase_d = i2cbm_pkg::PH_IDLE;
				end else if (poll_to) begin
					phase_d = i2cbm_pkg::PH_SP_A;
				end
			end
			i2cbm_pkg::PH_ST_A:  if (tick_end) phase_d = i2cbm_pkg::PH_ST_B;
			i2cbm_pkg::PH_ST_B:  if (tick_end) phase_d = i2cbm_pkg::PH_IDLE;
			i2cbm_pkg::PH_SP_A:  if (tick_end) phase_d = i2cbm_pkg::PH_SP_B;
			i2cbm_pkg::PH_SP_B:  if (tick_end) phase_d = i2cbm_pkg::PH_IDLE;
			i2cbm_pkg::PH_W_SET: if (tick_end) phase_d = i2cbm_pkg::PH_W_HI;
			i2cbm_pkg::PH_W_HI:  if (tick_end) phase_d = i2cbm_pkg::PH_W_LO;
			i2cbm_pkg::PH_W_LO: begin
				if (tick_end) begin
					phase_d = bit_last ? i2cbm_pkg::PH_A_REL : i2cbm_pkg::PH_W_SET;
				end
			end
			i2cbm_pkg::PH_A_REL: if (tick_end) phase_d = i2cbm_pkg::PH_A_HI;
			i2cbm_pkg::PH_A_HI:  if (tick_end) phase_d = i2cbm_pkg::PH_A_POLL;
			i2cbm_pkg::PH_R_LO:  if (tick_end) phase_d = i2cbm_pkg::PH_R_HI;
			i2cbm_pkg::PH_R_HI: begin
				if (tick_end) begin
					phase_d = bit_last ? i2cbm_pkg::PH_K_SET : i2cbm_pkg::PH_R_LO;
				end
			end
			i2cbm_pkg::PH_K_SET: if (tick_end) phase_d = i2cbm_pkg::PH_K_HI;
			i2cbm_pkg::PH_K_HI:  if (tick_end) phase_d = i2cbm_pkg::PH_IDLE;
			default:             phase_d = i2cbm_pkg::PH_IDLE;
		endcase
	end

	// Data path and status.
	always_comb begin
		shift_d    = shift_q;
		bit_d      = bit_q;
		poll_d     = poll_q;
		ack_flag_d = ack_flag_q;
		choice_d   = choice_q;
		rx_d       = rx_q;
		done_d     = 1'b0;
		unique case (phase_q)
			i2cbm_pkg::PH_IDLE: begin
				if (it.launch && it.cmd == i2cbm_pkg::CMD_WRITE) begin
					shift_d = it.tx_byte;
					bit_d   = '0;
				end else if (it.launch && it.cmd == i2cbm_pkg::CMD_READ) begin
					choice_d = it.send_ack;
					shift_d  = '0;
					bit_d    = '0;
				end
			end
			i2cbm_pkg::PH_A_POLL: begin
				if (!it.sda_in) begin
					ack_flag_d = 1'b0;
					done_d     = 1'b1;
				end else if (poll_to) begin
					ack_flag_d = 1'b1;
					poll_d     = '0;
				end else begin
					poll_d = poll_n[7:0];
				end
			end
			i2cbm_pkg::PH_A_HI: begin
				if (tick_end) poll_d = '0;
			end
			i2cbm_pkg::PH_W_LO: begin
				if (tick_end) begin
					shift_d = shift_w;
					bit_d   = bit_inc;
				end
			end
			i2cbm_pkg::PH_R_HI: begin
				if (tick_end) begin
					shift_d = shift_r;
					bit_d   = bit_inc;
					if (bit_last) rx_d = shift_r;
				end
			end
			i2cbm_pkg::PH_ST_B, i2cbm_pkg::PH_SP_B, i2cbm_pkg::PH_K_HI: begin
				done_d = tick_end;
			end
			default: ;
		endcase
	end

	// Line levels are set on entry to each phase; the counter restarts there.
	assign go = (phase_d != phase_q);

	always_comb begin
		scl_d  = scl_q;
		sda_d  = sda_q;
		drv_d  = drv_q;
		tick_d = tick_q;
		if (go) begin
			tick_d = '0;
			unique case (phase_d)
				i2cbm_pkg::PH_ST_A:   begin scl_d = 1'b1; sda_d = 1'b1;        drv_d = 1'b1; end
				i2cbm_pkg::PH_ST_B:   begin scl_d = 1'b1; sda_d = 1'b0;        drv_d = 1'b1; end
				i2cbm_pkg::PH_SP_A:   begin scl_d = 1'b0; sda_d = 1'b0;        drv_d = 1'b1; end
				i2cbm_pkg::PH_SP_B:   begin scl_d = 1'b1; sda_d = 1'b1;        drv_d = 1'b1; end
				i2cbm_pkg::PH_W_SET:  begin scl_d = 1'b0; sda_d = shift_d[7];  drv_d = 1'b1; end
				i2cbm_pkg::PH_W_HI:   begin scl_d = 1'b1;                      drv_d = 1'b1; end
				i2cbm_pkg::PH_W_LO:   begin scl_d = 1'b0;                      drv_d = 1'b1; end
				i2cbm_pkg::PH_A_REL:  begin scl_d = 1'b0; sda_d = 1'b1;        drv_d = 1'b0; end
				i2cbm_pkg::PH_A_HI:   begin scl_d = 1'b1; sda_d = 1'b1;        drv_d = 1'b0; end
				i2cbm_pkg::PH_A_POLL: begin scl_d = 1'b1; sda_d = 1'b1;        drv_d = 1'b0; end
				i2cbm_pkg::PH_R_LO:   begin scl_d = 1'b0;                      drv_d = 1'b0; end
				i2cbm_pkg::PH_R_HI:   begin scl_d = 1'b1;                      drv_d = 1'b0; end
				i2cbm_pkg::PH_K_SET:  begin scl_d = 1'b0; sda_d = !choice_d;   drv_d = 1'b1; end
				i2cbm_pkg::PH_K_HI:   begin scl_d = 1'b1;                      drv_d = 1'b1; end
				// Only a finished stop leaves SCL high when going idle.
				i2cbm_pkg::PH_IDLE:   scl_d = (phase_q == i2cbm_pkg::PH_SP_B);
				default: ;
			endcase
		end else if (phase_q != i2cbm_pkg::PH_IDLE && phase_q != i2cbm_pkg::PH_A_POLL) begin
			tick_d = tick_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cbm_pkg::PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b1;
			ack_flag_q  <= 1'b0;
			choice_q    <= 1'b0;
			rx_q        <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q    <= phase_d;
				tick_q     <= tick_d;
				bit_q      <= bit_d;
				shift_q    <= shift_d;
				poll_q     <= poll_d;
				scl_q      <= scl_d;
				sda_q      <= sda_d;
				drv_q      <= drv_d;
				ack_flag_q <= ack_flag_d;
				choice_q   <= choice_d;
				rx_q       <= rx_d;
				done_q     <= done_d;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_level   = scl_q;
	assign sda_level   = sda_q;
	assign sda_drive   = drv_q;
	assign busy_res    = (phase_q != i2cbm_pkg::PH_IDLE);
	assign cmd_done    = done_q;
	assign rx_byte     = rx_q;
	assign ack_missing = ack_flag_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == i2cbm_pkg::PH_IDLE)
		else $error("command finished while a phase is still running");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(phase_q) && $stable(tick_q) && $stable(done_q))
		else $error("engine advanced while its result was stalled");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= i2cbm_pkg::BYTE_BITS)
		else $error("bit counter ran past one byte");

	a_poll_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cbm_pkg::PH_A_POLL |-> !drv_q && scl_q)
		else $error("SDA driven or SCL low while polling for acknowledge");

endmodule

// ===== hdl/i2c_byte_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_byte_master
// Byte-level I2C master advanced by one timing tick per transfer: start,
// stop, byte write with acknowledge check, byte read with ACK or NACK.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        to block   in_valid / in_ready    cmd_valid func tx_byte send_ack sda_in
//  out       from block out_valid / out_ready  scl_level sda_level sda_drive busy_res
//                                              cmd_done rx_byte ack_missing
//  cfg       to block   cfg_valid / cfg_ready  cfg_index cfg_data
//
//  One tick is taken per cycle while in_ready is high and gives one result.
//  The tick waits in a queue slot, the engine registers load its result, and
//  the result transfers out from them. The engine advances one tick per cycle
//  while its result is not stalled; its result register sets the rate.
//  Once the output stalls the two-entry queue takes one more tick, then
//  in_ready drops until the stall clears. Reset puts SCL and SDA high and
//  driven, the phase idle and the registers at their reset values; cfg_ready
//  is always high.
// ----------------------------------------------------------------------------
module i2c_byte_master (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd_valid,
	input  logic [1:0]                           func,
	input  logic [7:0]                           tx_byte,
	input  logic                                 send_ack,
	input  logic                                 sda_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 scl_level,
	output logic                                 sda_level,
	output logic                                 sda_drive,
	output logic                                 busy_res,
	output logic                                 cmd_done,
	output logic [7:0]                           rx_byte,
	output logic                                 ack_missing,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [i2cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                           cfg_data
);

	i2cbm_pkg::cfg_t  cfg_q;
	i2cbm_pkg::item_t q_item;
	logic             q_valid;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_phase_ticks   <= i2cbm_pkg::BIT_PHASE_RST;
			cfg_q.start_stop_ticks  <= i2cbm_pkg::START_STOP_RST;
			cfg_q.ack_timeout_polls <= i2cbm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				i2cbm_pkg::CFG_BIT_PHASE:   cfg_q.bit_phase_ticks   <= cfg_data;
				i2cbm_pkg::CFG_START_STOP:  cfg_q.start_stop_ticks  <= cfg_data;
				i2cbm_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout_polls <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd_valid (cmd_valid),
		.func      (func),
		.tx_byte   (tx_byte),
		.send_ack  (send_ack),
		.sda_in    (sda_in),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	i2cbm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_level   (scl_level),
		.sda_level   (sda_level),
		.sda_drive   (sda_drive),
		.busy_res    (busy_res),
		.cmd_done    (cmd_done),
		.rx_byte     (rx_byte),
		.ack_missing (ack_missing)
	);

endmodule

// ===== sim/i2c_byte_master_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_byte_master_tb
// Self-checking bench for the byte-level I2C master. A directed run covers
// start, stop, writes with prompt, late and missing acknowledge, and reads with
// ACK and NACK. Randomized command streams then run under several timing
// settings, including zero lengths and timeouts; one write runs at full-scale
// start and stop lengths and timeout. Every tick transfer is predicted by a
// local engine model; each output transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module i2c_byte_master_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [i2cbm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		i2cbm_pkg::phase_t ph;
		logic [7:0] ticks;
		logic [3:0] bits;
		logic [7:0] shreg;
		logic [7:0] polls;
		logic       scl;
		logic       sda;
		logic       drv;
		logic       ack_miss;
		logic       ack_sel;
		logic [7:0] rx;
	} bus_state_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       miss;
	} line_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd_valid = 1'b0;
	logic [1:0] func = '0;
	logic [7:0] tx_byte = '0;
	logic send_ack = 1'b0;
	logic sda_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_level;
	logic sda_level;
	logic sda_drive;
	logic busy_res;
	logic cmd_done;
	logic [7:0] rx_byte;
	logic ack_missing;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [i2cbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	i2c_byte_master uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd_valid  (cmd_valid),
		.func       (func),
		.tx_byte    (tx_byte),
		.send_ack   (send_ack),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.sda_drive  (sda_drive),
		.busy_res   (busy_res),
		.cmd_done   (cmd_done),
		.rx_byte    (rx_byte),
		.ack_missing(ack_missing),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	i2cbm_pkg::cfg_t  bus_cfg;
	bus_state_t       plan_st;
	bus_state_t       engine_st;
	bus_state_t       engine_next;
	line_view_t       engine_view;
	i2cbm_pkg::item_t offered;

	i2cbm_pkg::item_t tick_q[$];
	line_view_t       line_q[$];
	int               line_stamp_q[$];

	int items_queued = 0;
	int results_seen = 0;
	int mismatches = 0;
	int drv_edge = 0;
	int mon_edge = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int ready_mode = 0;
	logic stall_req = 1'b0;
	logic stall_taken = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bus_state_t bus_idle_state();
		bus_state_t s;
		s = '0;
		s.ph = i2cbm_pkg::PH_IDLE;
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.drv = 1'b1;
		return s;
	endfunction

	function automatic bus_state_t move_to(input bus_state_t s, input i2cbm_pkg::phase_t ph,
			input logic scl, input logic sda, input logic drv);
		bus_state_t r;
		r = s;
		r.ph = ph;
		r.ticks = '0;
		r.scl = scl;
		r.sda = sda;
		r.drv = drv;
		return r;
	endfunction

	function automatic logic [7:0] phase_span(input i2cbm_pkg::phase_t ph,
			input i2cbm_pkg::cfg_t c);
		logic [7:0] v;
		v = (ph >= i2cbm_pkg::PH_ST_A && ph <= i2cbm_pkg::PH_SP_B) ?
			c.start_stop_ticks : c.bit_phase_ticks;
		// A zero setting still holds the phase for one tick.
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	// Advances the bus engine by one tick and returns the line levels after it.
	function automatic line_view_t bus_tick(input bus_state_t cur, input i2cbm_pkg::cfg_t c,
			input i2cbm_pkg::item_t it, output bus_state_t nxt);
		bus_state_t s;
		logic done;
		logic [8:0] polls_next;
		line_view_t v;
		s = cur;
		done = 1'b0;
		if (s.ph == i2cbm_pkg::PH_IDLE) begin
			if (it.launch) begin
				case (it.cmd)
					i2cbm_pkg::CMD_START:
						s = move_to(s, i2cbm_pkg::PH_ST_A, 1'b1, 1'b1, 1'b1);
					i2cbm_pkg::CMD_STOP:
						s = move_to(s, i2cbm_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1);
					i2cbm_pkg::CMD_WRITE: begin
						s.shreg = it.tx_byte;
						s.bits = '0;
						s = move_to(s, i2cbm_pkg::PH_W_SET, 1'b0, it.tx_byte[7], 1'b1);
					end
					default: begin
						s.ack_sel = it.send_ack;
						s.shreg = '0;
						s.bits = '0;
						s = move_to(s, i2cbm_pkg::PH_R_LO, 1'b0, s.sda, 1'b0);
					end
				endcase
			end
		end else if (s.ph == i2cbm_pkg::PH_A_POLL) begin
			if (!it.sda_in) begin
				s.ack_miss = 1'b0;
				done = 1'b1;
				s = move_to(s, i2cbm_pkg::PH_IDLE, 1'b0, s.sda, s.drv);
			end else begin
				polls_next = {1'b0, s.polls} + 9'd1;
				if (polls_next > {1'b0, c.ack_timeout_polls}) begin
					// The acknowledge never came: flag it and release the bus.
					s.ack_miss = 1'b1;
					s.polls = '0;
					s = move_to(s, i2cbm_pkg::PH_SP_A, 1'b0, 1'b0, 1'b1);
				end else begin
					s.polls = polls_next[7:0];
				end
			end
		end else begin
			s.ticks = s.ticks + 8'd1;
			if (s.ticks >= phase_span(s.ph, c)) begin
				case (s.ph)
					i2cbm_pkg::PH_ST_A:
						s = move_to(s, i2cbm_pkg::PH_ST_B, 1'b1, 1'b0, 1'b1);
					i2cbm_pkg::PH_ST_B: begin
						done = 1'b1;
						s = move_to(s, i2cbm_pkg::PH_IDLE, 1'b0, 1'b0, 1'b1);
					end
					i2cbm_pkg::PH_SP_A:
						s = move_to(s, i2cbm_pkg::PH_SP_B, 1'b1, 1'b1, 1'b1);
					i2cbm_pkg::PH_SP_B: begin
						done = 1'b1;
						s = move_to(s, i2cbm_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1);
					end
					i2cbm_pkg::PH_W_SET:
						s = move_to(s, i2cbm_pkg::PH_W_HI, 1'b1, s.sda, 1'b1);
					i2cbm_pkg::PH_W_HI:
						s = move_to(s, i2cbm_pkg::PH_W_LO, 1'b0, s.sda, 1'b1);
					i2cbm_pkg::PH_W_LO: begin
						s.shreg = s.shreg << 1;
						s.bits = s.bits + 4'd1;
						if (s.bits >= i2cbm_pkg::BYTE_BITS) begin
							s = move_to(s, i2cbm_pkg::PH_A_REL, 1'b0, 1'b1, 1'b0);
						end else begin
							s = move_to(s, i2cbm_pkg::PH_W_SET, 1'b0, s.shreg[7], 1'b1);
						end
					end
					i2cbm_pkg::PH_A_REL:
						s = move_to(s, i2cbm_pkg::PH_A_HI, 1'b1, 1'b1, 1'b0);
					i2cbm_pkg::PH_A_HI: begin
						s.polls = '0;
						s = move_to(s, i2cbm_pkg::PH_A_POLL, 1'b1, 1'b1, 1'b0);
					end
					i2cbm_pkg::PH_R_LO:
						s = move_to(s, i2cbm_pkg::PH_R_HI, 1'b1, s.sda, 1'b0);
					i2cbm_pkg::PH_R_HI: begin
						s.shreg = {s.shreg[6:0], it.sda_in};
						s.bits = s.bits + 4'd1;
						if (s.bits >= i2cbm_pkg::BYTE_BITS) begin
							s.rx = s.shreg;
							s = move_to(s, i2cbm_pkg::PH_K_SET, 1'b0, ~s.ack_sel, 1'b1);
						end else begin
							s = move_to(s, i2cbm_pkg::PH_R_LO, 1'b0, s.sda, 1'b0);
						end
					end
					i2cbm_pkg::PH_K_SET:
						s = move_to(s, i2cbm_pkg::PH_K_HI, 1'b1, s.sda, 1'b1);
					i2cbm_pkg::PH_K_HI: begin
						done = 1'b1;
						s = move_to(s, i2cbm_pkg::PH_IDLE, 1'b0, s.sda, 1'b1);
					end
					default: s = move_to(s, i2cbm_pkg::PH_IDLE, s.scl, s.sda, s.drv);
				endcase
			end
		end
		nxt = s;
		v.scl = s.scl;
		v.sda = s.sda;
		v.drv = s.drv;
		v.busy = (s.ph != i2cbm_pkg::PH_IDLE);
		v.done = done;
		v.rx = s.rx;
		v.miss = s.ack_miss;
		return v;
	endfunction

	function automatic string show_lines(input line_view_t v);
		return $sformatf("scl %0b sda %0b oe %0b busy %0b done %0b rx %02h nack %0b",
			v.scl, v.sda, v.drv, v.busy, v.done, v.rx, v.miss);
	endfunction

	// The planning copy of the engine lets the stimulus follow the bus phases.
	task automatic queue_tick(input i2cbm_pkg::item_t it);
		bus_state_t nxt;
		line_view_t ignored;
		ignored = bus_tick(plan_st, bus_cfg, it, nxt);
		plan_st = nxt;
		tick_q.push_back(it);
		items_queued++;
	endtask

	task automatic idle_ticks(input int n);
		i2cbm_pkg::item_t it;
		repeat (n) begin
			it.launch = 1'b0;
			it.cmd = i2cbm_pkg::cmd_t'($urandom_range(0, 3));
			it.tx_byte = 8'($urandom_range(0, 255));
			it.send_ack = 1'($urandom_range(0, 1));
			it.sda_in = 1'($urandom_range(0, 1));
			queue_tick(it);
		end
	endtask

	// Issues one command and the ticks that carry it to completion. A negative
	// ack_after keeps SDA high so the acknowledge times out.
	task automatic run_command(input i2cbm_pkg::cmd_t c, input logic [7:0] data,
			input logic ack_sel, input int ack_after);
		i2cbm_pkg::item_t it;
		int polls;
		polls = 0;
		it.launch = 1'b1;
		it.cmd = c;
		it.tx_byte = data;
		it.send_ack = ack_sel;
		it.sda_in = 1'($urandom_range(0, 1));
		queue_tick(it);
		while (plan_st.ph != i2cbm_pkg::PH_IDLE) begin
			// Commands offered while busy must be ignored.
			it.launch = ($urandom_range(0, 7) == 0);
			it.cmd = i2cbm_pkg::cmd_t'($urandom_range(0, 3));
			it.tx_byte = 8'($urandom_range(0, 255));
			it.send_ack = 1'($urandom_range(0, 1));
			if (plan_st.ph == i2cbm_pkg::PH_A_POLL) begin
				it.sda_in = (ack_after >= 0 && polls >= ack_after) ? 1'b0 : 1'b1;
				polls++;
			end else if (plan_st.ph == i2cbm_pkg::PH_R_HI) begin
				it.sda_in = data[3'd7 - plan_st.bits[2:0]];
			end else begin
				it.sda_in = 1'($urandom_range(0, 1));
			end
			queue_tick(it);
		end
	endtask

	task automatic random_traffic(input int budget);
		int stop_at;
		int r;
		int ack_after;
		logic [7:0] data;
		stop_at = items_queued + budget;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				idle_ticks($urandom_range(1, 3));
			end else begin
				r = $urandom_range(0, 19);
				if (r < 14) begin
					ack_after = $urandom_range(0, 3);
				end else if (r < 17) begin
					ack_after = $urandom_range(4, 12);
				end else begin
					ack_after = -1;
				end
				r = $urandom_range(0, 7);
				data = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
				run_command(i2cbm_pkg::cmd_t'($urandom_range(0, 3)), data,
					1'($urandom_range(0, 1)), ack_after);
			end
		end
	endtask

	// Waits until every queued tick has produced its checked result.
	task automatic settle();
		while (results_seen < items_queued) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] bp, input logic [7:0] ss,
			input logic [7:0] to, input logic spare);
		logic [i2cbm_pkg::CFG_IDX_W-1:0] idx [0:3];
		logic [7:0] val [0:3];
		int n;
		int k;
		idx[0] = i2cbm_pkg::CFG_BIT_PHASE;
		val[0] = bp;
		idx[1] = i2cbm_pkg::CFG_START_STOP;
		val[1] = ss;
		idx[2] = i2cbm_pkg::CFG_ACK_TIMEOUT;
		val[2] = to;
		idx[3] = CFG_UNUSED_IDX;
		val[3] = 8'($urandom_range(0, 255));
		n = spare ? 4 : 3;
		@(posedge clk);
		for (k = 0; k < n; k++) begin
			cfg_index <= idx[k];
			cfg_data <= val[k];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx[k])
				i2cbm_pkg::CFG_BIT_PHASE:   bus_cfg.bit_phase_ticks = val[k];
				i2cbm_pkg::CFG_START_STOP:  bus_cfg.start_stop_ticks = val[k];
				i2cbm_pkg::CFG_ACK_TIMEOUT: bus_cfg.ack_timeout_polls = val[k];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Sender: offers queued ticks in bursts and predicts each accepted one.
	always @(posedge clk) begin
		drv_edge++;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				engine_view = bus_tick(engine_st, bus_cfg, offered, engine_next);
				engine_st = engine_next;
				line_q.push_back(engine_view);
				line_stamp_q.push_back(drv_edge);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					offered = tick_q.pop_front();
					in_valid <= 1'b1;
					cmd_valid <= offered.launch;
					func <= offered.cmd;
					tx_byte <= offered.tx_byte;
					send_ack <= offered.send_ack;
					sda_in <= offered.sda_in;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						if ($urandom_range(0, 2) == 0) begin
							gap_left = 0;
						end else if ($urandom_range(0, 5) == 0) begin
							gap_left = $urandom_range(1, 20);
						end else begin
							gap_left = $urandom_range(1, 4);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each output transfer and stalls on its own pattern.
	always @(posedge clk) begin
		line_view_t want;
		line_view_t got;
		mon_edge++;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = {scl_level, sda_level, sda_drive, busy_res, cmd_done, rx_byte, ack_missing};
			// An expectation stamped on this same edge cannot have a result yet.
			if (line_q.size() == 0 || line_stamp_q[0] >= mon_edge) begin
				if (mismatches < 10) $display("unexpected result: %s", show_lines(got));
				mismatches++;
			end else begin
				want = line_q.pop_front();
				line_stamp_q.delete(0);
				if (got != want) begin
					if (mismatches < 10) begin
						$display("mismatch at result %0d", results_seen);
						$display("  expected %s", show_lines(want));
						$display("  actual   %s", show_lines(got));
					end
					mismatches++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_req && !stall_taken) begin
			stall_taken = 1'b1;
			hold_left = 150;
			out_ready <= 1'b0;
		end else begin
			if (mon_edge % 50 == 0) ready_mode = $urandom_range(0, 3);
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= mon_edge[0];
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen",
				cycle_cnt, results_seen, items_queued);
			$display("i2c_byte_master_tb: done, errors");
			$finish;
		end
	end

	initial begin
		bus_cfg.bit_phase_ticks = i2cbm_pkg::BIT_PHASE_RST;
		bus_cfg.start_stop_ticks = i2cbm_pkg::START_STOP_RST;
		bus_cfg.ack_timeout_polls = i2cbm_pkg::ACK_TIMEOUT_RST;
		engine_st = bus_idle_state();
		plan_st = engine_st;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands at the reset timing.
		idle_ticks(2);
		run_command(i2cbm_pkg::CMD_START, 8'h3C, 1'b0, 0);
		run_command(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b0, 0);
		run_command(i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b1, 2);
		run_command(i2cbm_pkg::CMD_WRITE, 8'hA5, 1'b0, -1);
		run_command(i2cbm_pkg::CMD_WRITE, 8'h5A, 1'b1, 0);
		run_command(i2cbm_pkg::CMD_READ, 8'hFF, 1'b1, 0);
		run_command(i2cbm_pkg::CMD_READ, 8'h00, 1'b0, 0);
		run_command(i2cbm_pkg::CMD_READ, 8'h96, 1'b1, 0);
		run_command(i2cbm_pkg::CMD_STOP, 8'hC3, 1'b1, 0);
		idle_ticks(2);
		settle();

		// Zero lengths count as one tick, and a zero timeout fails on the first
		// high poll.
		load_settings(8'd0, 8'd0, 8'd0, 1'b1);
		run_command(i2cbm_pkg::CMD_WRITE, 8'hC3, 1'b0, -1);
		run_command(i2cbm_pkg::CMD_START, 8'h00, 1'b0, 0);
		run_command(i2cbm_pkg::CMD_READ, 8'h69, 1'b0, 0);
		run_command(i2cbm_pkg::CMD_STOP, 8'hFF, 1'b1, 0);
		random_traffic(80);
		settle();

		// The receiver holds off for a long stretch while this phase is queued.
		load_settings(8'd1, 8'd1, 8'd1, 1'b0);
		random_traffic(150);
		stall_req = 1'b1;
		settle();

		load_settings(8'd3, 8'd5, 8'd4, 1'b0);
		random_traffic(80);
		settle();

		// Full-scale start and stop lengths and timeout on a single write.
		load_settings(8'd1, 8'd255, 8'd255, 1'b1);
		run_command(i2cbm_pkg::CMD_WRITE, 8'h81, 1'b1, -1);
		settle();

		load_settings(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
			8'($urandom_range(0, 6)), 1'b0);
		random_traffic(80);
		settle();
		repeat (8) @(posedge clk);

		if (line_q.size() != 0) begin
			$display("%0d expected results never arrived", line_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("i2c_byte_master_tb: done, clean");
		end else begin
			$display("i2c_byte_master_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== i2c_byte_master.f =====
hdl/i2cbm_pkg.sv
hdl/i2cbm_front.sv
hdl/i2cbm_engine.sv
hdl/i2c_byte_master.sv
sim/i2c_byte_master_tb.sv
